@@ rtl/core/rtks_pkg.sv @@
// Package for the row top-k selection unit: constants, payload structs, rank key.
// No dependencies.
package rtks_pkg;
  localparam int MaxK = 8;
  localparam int MaxColumns = 256;
  localparam int CountW = 4;
  localparam int ScoreW = 32;
  localparam int ColW = 8;

  typedef struct packed {
    logic [ScoreW-1:0] score_bits;
    logic              row_end;
  } in_item_t;

  typedef struct packed {
    logic [ScoreW-1:0] top_value;
    logic [ColW-1:0]   top_column;
    logic              final_of_row;
  } out_item_t;

  // Monotone rank key: NaN is zero, numbers map above it in value order.
  function automatic logic [32:0] rank_key(input logic [31:0] bits);
    logic [30:0] mag;
    mag = bits[30:0];
    if (mag > 31'h7F800000) begin
      rank_key = 33'd0;
    end else if (bits[31] && (mag != 31'd0)) begin
      rank_key = 33'h080000000 - {2'b00, mag};
    end else begin
      rank_key = 33'h080000000 + {2'b00, mag};
    end
  endfunction
endpackage

@@ rtl/core/row_top_k_select_unit.sv @@
// Top level of the row top-k selection unit.
// Depends on rtks_pkg, rtks_list and rtks_emit.
//
// The unit takes one fp32 score per transfer and keeps, for the current row, a
// sorted list of the k highest scores (k from cfg top_count, 0 acting as 1 and
// values above MAX_K as MAX_K) with their columns. Ranking is descending by
// value with ties broken by lower column; the two zeros are equal and any NaN
// ranks below every number. Scores are accepted one per cycle: the insertion
// compares the new score with all list entries at once. On the score marked
// row_end the finished list is copied into a result buffer and transferred out
// in rank order, one result per cycle while out_ready is high, the last marked
// final_of_row; the next row streams in meanwhile. A following row end is held
// off only while the previous row's results are still draining, so rows of at
// least k scores run at full rate while out_ready stays high. Scores beyond
// MAX_COLUMNS in a row are ignored, though their row_end mark still closes the
// row. There is no clearing pass after reset.
module row_top_k_select_unit #(
  parameter int MAX_K = rtks_pkg::MaxK,
  parameter int MAX_COLUMNS = rtks_pkg::MaxColumns
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rtks_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rtks_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [rtks_pkg::CountW-1:0] cfg_data
);
  logic [rtks_pkg::CountW-1:0] top_count_r;
  logic [rtks_pkg::ScoreW-1:0] snap_values [MAX_K];
  logic [rtks_pkg::ColW-1:0]   snap_columns [MAX_K];
  logic [$clog2(MAX_K+1)-1:0]  snap_count;
  logic                        busy, step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= rtks_pkg::CountW'(1);
    end else if (cfg_we) begin
      top_count_r <= cfg_data;
    end
  end

  // Ordinary scores always go in; a row end waits for a free result buffer.
  assign in_ready = !(in_item.row_end && busy);
  assign step     = in_valid && in_ready;

  rtks_list #(.MAX_K(MAX_K), .MAX_COLUMNS(MAX_COLUMNS)) u_list (
    .clk(clk), .rst_n(rst_n), .step(step), .item(in_item), .top_count(top_count_r),
    .snap_values(snap_values), .snap_columns(snap_columns), .snap_count(snap_count)
  );

  rtks_emit #(.MAX_K(MAX_K)) u_emit (
    .clk(clk), .rst_n(rst_n), .load(step && in_item.row_end),
    .ld_values(snap_values), .ld_columns(snap_columns), .ld_count(snap_count),
    .busy(busy), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );
endmodule

@@ rtl/core/rtks_list.sv @@
// Sorted list of the k best scores of the current row, one insertion per cycle while step is high.
// Depends on rtks_pkg.
module rtks_list #(
  parameter int MAX_K = rtks_pkg::MaxK,
  parameter int MAX_COLUMNS = rtks_pkg::MaxColumns
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  rtks_pkg::in_item_t          item,
  input  logic [rtks_pkg::CountW-1:0] top_count,
  output logic [rtks_pkg::ScoreW-1:0] snap_values [MAX_K],
  output logic [rtks_pkg::ColW-1:0]   snap_columns [MAX_K],
  output logic [$clog2(MAX_K+1)-1:0]  snap_count
);
  localparam int NW = $clog2(MAX_K + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [rtks_pkg::ScoreW-1:0] val_r [MAX_K];
  logic [rtks_pkg::ColW-1:0]   col_r [MAX_K];
  logic [NW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               colc_r, colc_nxt;
  logic [NW-1:0]               k_eff, n_cur;
  logic [MAX_K-1:0]            ge;
  logic [32:0]                 key;
  logic                        take;

  always_comb begin
    if (top_count == '0) begin
      k_eff = NW'(1);
    end else if (32'(top_count) > MAX_K) begin
      k_eff = NW'(MAX_K);
    end else begin
      k_eff = NW'(top_count);
    end
    n_cur = (cnt_r < k_eff) ? cnt_r : k_eff;
    take  = (32'(colc_r) < MAX_COLUMNS);
    key   = rtks_pkg::rank_key(item.score_bits);
  end

  // Entry i stays ahead of the new score when it is valid and ranks at least as high.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cmp
    assign ge[i] = (NW'(i) < n_cur) && (rtks_pkg::rank_key(val_r[i]) >= key);
  end

  always_comb begin
    cnt_nxt  = n_cur;
    colc_nxt = colc_r;
    if (take) begin
      if (n_cur < k_eff) cnt_nxt = n_cur + NW'(1);
      colc_nxt = colc_r + CW'(1);
    end
    if (item.row_end) begin
      cnt_nxt  = '0;
      colc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      colc_r <= '0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      colc_r <= colc_nxt;
    end
  end

  // Since ge is a prefix, entry i takes the new score at the insertion point,
  // its predecessor below it, and is kept otherwise.
  for (genvar i = 0; i < MAX_K; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (step && take && (NW'(i) < k_eff) && !ge[i]) begin
        if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
          val_r[i] <= item.score_bits;
          col_r[i] <= rtks_pkg::ColW'(colc_r);
        end else begin
          val_r[i] <= val_r[(i == 0) ? 0 : i-1];
          col_r[i] <= col_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // Row contents after this step, for the emitter.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      snap_values[i]  = val_r[i];
      snap_columns[i] = col_r[i];
      if (take && (NW'(i) < k_eff) && !ge[i]) begin
        if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
          snap_values[i]  = item.score_bits;
          snap_columns[i] = rtks_pkg::ColW'(colc_r);
        end else begin
          snap_values[i]  = val_r[(i == 0) ? 0 : i-1];
          snap_columns[i] = col_r[(i == 0) ? 0 : i-1];
        end
      end
    end
    snap_count = (take && (n_cur < k_eff)) ? n_cur + NW'(1) : n_cur;
  end
endmodule

@@ rtl/core/rtks_emit.sv @@
// Result buffer: holds a finished row and transfers it one result per cycle while out_ready is high.
// Depends on rtks_pkg.
module rtks_emit #(
  parameter int MAX_K = rtks_pkg::MaxK
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [rtks_pkg::ScoreW-1:0] ld_values [MAX_K],
  input  logic [rtks_pkg::ColW-1:0]   ld_columns [MAX_K],
  input  logic [$clog2(MAX_K+1)-1:0]  ld_count,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rtks_pkg::out_item_t         out_item
);
  localparam int NW = $clog2(MAX_K + 1);
  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  logic [rtks_pkg::ScoreW-1:0] val_r [MAX_K];
  logic [rtks_pkg::ColW-1:0]   col_r [MAX_K];
  logic [NW-1:0]               left_r;
  logic [IW-1:0]               idx_r;

  assign out_valid = (left_r != '0);
  // Busy until the last result of the row is leaving.
  assign busy = out_valid && !(out_ready && left_r == NW'(1));
  assign out_item.top_value    = val_r[idx_r];
  assign out_item.top_column   = col_r[idx_r];
  assign out_item.final_of_row = (left_r == NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      idx_r  <= '0;
    end else if (load) begin
      left_r <= ld_count;
      idx_r  <= '0;
    end else if (out_valid && out_ready) begin
      left_r <= left_r - NW'(1);
      idx_r  <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= ld_values;
      col_r <= ld_columns;
    end
  end
endmodule

@@ rtl/core/rtks_checker.sv @@
// Port-level checker for the row top-k selection unit, bound to the top level.
// Depends on rtks_pkg.
module rtks_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rtks_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input rtks_pkg::out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("offered score withdrawn or changed before its transfer");

  a_score_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.row_end |-> in_ready)
    else $error("ordinary score refused");

  a_row_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.final_of_row && in_item.row_end |-> in_ready)
    else $error("row end held while buffer frees");

  a_no_out_after_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind row_top_k_select_unit rtks_checker u_rtks_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
